// ===== src/ecgp_pkg.sv =====
// Shared types, constants and exp tables for the exponential cluster grid point unit.
// Depends on nothing; imported by ecgp_exp, the top level and the testbench.
`default_nettype none

package ecgp_pkg;

    localparam int MAX_POINTS = 1024;

    typedef struct packed {
        logic [9:0] column_index;
        logic [9:0] row_index;
    } t_req;

    typedef struct packed {
        logic [16:0] x_coord;
        logic [20:0] y_coord;
        logic        index_error;
    } t_res;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic        bot;
        logic        top;
        logic        up;
        logic [16:0] x;
        logic [20:0] h;
    } t_tag;

    typedef logic [30:0] t_ftab [65];
    typedef logic [30:0] t_wtab [17];

    // shift and subtract quotient, elaboration only
    function automatic longint unsigned long_div(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_ftab mk_frac();
        t_ftab           tab;
        longint unsigned term;
        longint unsigned sum;
        logic            done;
        for (int k = 0; k < 65; k++) begin
            term = 64'd1 << 32;
            sum  = term;
            done = 1'b0;
            for (int n = 1; n <= 24; n++) begin
                if (!done) begin
                    term = long_div(term * 64'(k), 64'(64 * n));
                    if (term == 64'd0) begin
                        done = 1'b1;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            tab[k] = 31'(long_div((64'd1 << 62) + (sum >> 1), sum));
        end
        return tab;
    endfunction

    function automatic t_wtab mk_whole();
        t_ftab           ft;
        t_wtab           tab;
        longint unsigned v;
        ft     = mk_frac();
        v      = 64'd1 << 30;
        tab[0] = 31'(v);
        for (int j = 1; j < 17; j++) begin
            v      = (v * 64'(ft[64]) + (64'd1 << 29)) >> 30;
            tab[j] = 31'(v);
        end
        return tab;
    endfunction

    localparam t_ftab FRAC_TAB  = mk_frac();
    localparam t_wtab WHOLE_TAB = mk_whole();

endpackage

`default_nettype wire

// ===== src/ecgp_chan.sv =====
// Valid/ready channel carrying one payload beat of type T.
// Payload types come from ecgp_pkg at the instance.
`default_nettype none

interface ecgp_chan #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/ecgp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and sideband.
// Standalone; used by the top level of the grid point unit.
`default_nettype none

module ecgp_div #(
    parameter int NW = 28,
    parameter int DW = 11,
    parameter int QW = 17,
    parameter int SW = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic      [QW-1:0] o_quo,
    output logic               o_ovf,
    output logic      [SW-1:0] o_side
);

    localparam int RW = NW - QW;
    localparam int CW = (RW > DW) ? RW : DW;

    logic [DW-1:0] w_rem  [QW+1];
    logic [QW-1:0] w_lq   [QW+1];
    logic [DW-1:0] w_den  [QW+1];
    logic          w_ovf  [QW+1];
    logic [SW-1:0] w_side [QW+1];

    assign w_rem[0]  = DW'(i_num[NW-1:QW]);
    assign w_lq[0]   = i_num[QW-1:0];
    assign w_den[0]  = i_den;
    assign w_ovf[0]  = CW'(i_num[NW-1:QW]) >= CW'(i_den);
    assign w_side[0] = i_side;

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW:0]   w_try;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [DW-1:0] r_rem;
        logic [QW-1:0] r_lq;
        logic [DW-1:0] r_den;
        logic          r_ovf;
        logic [SW-1:0] r_side;

        assign w_try = {w_rem[g], w_lq[g][QW-1]};
        assign w_ge  = w_try >= {1'b0, w_den[g]};
        assign n_rem = w_ge ? DW'(w_try - {1'b0, w_den[g]}) : DW'(w_try);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_lq  <= {w_lq[g][QW-2:0], w_ge};
                r_den <= w_den[g];
                r_ovf <= w_ovf[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side <= '0;
            end else if (i_en) begin
                r_side <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_lq[g+1]   = r_lq;
        assign w_den[g+1]  = r_den;
        assign w_ovf[g+1]  = r_ovf;
        assign w_side[g+1] = r_side;
    end

    assign o_quo  = w_lq[QW];
    assign o_ovf  = w_ovf[QW];
    assign o_side = w_side[QW];

endmodule

`default_nettype wire

// ===== src/ecgp_exp.sv =====
// Five-stage exp(-u) unit: table lookup, linear interpolation, whole-part scaling, Q1.30 out.
// Depends on ecgp_pkg for the fraction and whole-number tables.
`default_nettype none

module ecgp_exp
    import ecgp_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [21:0]   i_u,
    input  wire logic [SW-1:0] i_side,
    output logic      [30:0]   o_e,
    output logic      [SW-1:0] o_side
);

    logic [5:0]  w_j;
    logic [5:0]  w_k;
    logic [30:0] w_a;
    logic [30:0] w_b;
    logic [30:0] w_bm;
    logic [30:0] w_p;

    logic [30:0] r1_a;
    logic [30:0] r1_dif;
    logic [9:0]  r1_r;
    logic [30:0] r1_p;
    logic [40:0] r2_m;
    logic [30:0] r2_a;
    logic [30:0] r2_p;
    logic [30:0] r3_v;
    logic [30:0] r3_p;
    logic [61:0] r4_w;
    logic [30:0] r5_e;
    logic [SW-1:0] r_side [5];

    assign w_j  = i_u[21:16];
    assign w_k  = i_u[15:10];
    assign w_a  = FRAC_TAB[{1'b0, w_k}];
    assign w_b  = FRAC_TAB[7'({1'b0, w_k}) + 7'd1];
    assign w_bm = (w_b > w_a) ? w_a : w_b;
    assign w_p  = (w_j > 6'd16) ? 31'd0 : WHOLE_TAB[w_j[4:0]];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= w_a;
            r1_dif <= w_a - w_bm;
            r1_r   <= i_u[9:0];
            r1_p   <= w_p;
            r2_m   <= 41'(r1_dif) * 41'(r1_r);
            r2_a   <= r1_a;
            r2_p   <= r1_p;
            r3_v   <= r2_a - 31'((r2_m + 41'd512) >> 10);
            r3_p   <= r2_p;
            r4_w   <= 62'(r3_v) * 62'(r3_p);
            r5_e   <= 31'((r4_w + (62'd1 << 29)) >> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) r_side[s] <= '0;
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int s = 1; s < 5; s++) r_side[s] <= r_side[s-1];
        end
    end

    assign o_e    = r5_e;
    assign o_side = r_side[4];

endmodule

`default_nettype wire

// ===== src/exponential_cluster_grid_point_unit.sv =====
// Top level of the exponential cluster grid point unit: config registers and main pipeline.
// Depends on ecgp_pkg, ecgp_chan, ecgp_div and ecgp_exp.
//
// Each request beat names a grid node by column and row and yields one result beat with x in
// Q1.16, y in Q5.16 and an index error flag. The unit takes one beat per cycle unless stalled,
// and its depth comes from three 17-stage restoring dividers in series (column and row ratios,
// the stretch coordinate, and the normalized stretch factor), plus a five-stage exp unit and
// the multiply stages. The whole pipeline holds when a result waits at the output and the
// sink is not ready. Write configuration only while no beat is in flight; there is no
// clearing pass after reset.
`default_nettype none

module exponential_cluster_grid_point_unit
    import ecgp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data,
    ecgp_chan.sink           i_req,
    ecgp_chan.source         o_res
);

    typedef enum logic [2:0] {
        CFG_COLS  = 3'd0,
        CFG_ROWS  = 3'd1,
        CFG_BASE  = 3'd2,
        CFG_ALPHA = 3'd3,
        CFG_ETA0  = 3'd4
    } t_cfg;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [10:0] MAXC    = 11'(MAX_POINTS);

    logic [10:0] r_cols;
    logic [10:0] r_rows;
    logic [19:0] r_base;
    logic [15:0] r_alpha;
    logic [15:0] r_eta0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= 11'd50;
            r_rows  <= 11'd50;
            r_base  <= 20'd32768;
            r_alpha <= 16'd20480;
            r_eta0  <= 16'd45875;
        end else if (i_cfg_we) begin
            unique case (t_cfg'(i_cfg_idx))
                CFG_COLS:  r_cols  <= i_cfg_data[10:0];
                CFG_ROWS:  r_rows  <= i_cfg_data[10:0];
                CFG_BASE:  r_base  <= i_cfg_data;
                CFG_ALPHA: r_alpha <= i_cfg_data[15:0];
                CFG_ETA0:  r_eta0  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [10:0] w_nc;
    logic [10:0] w_nr;
    logic [10:0] w_dc;
    logic [10:0] w_dr;
    logic [15:0] w_alpha;
    logic [15:0] w_eta0;
    logic [16:0] w_rest;
    logic        w_adv;

    assign w_nc    = (r_cols > MAXC) ? MAXC : r_cols;
    assign w_nr    = (r_rows > MAXC) ? MAXC : r_rows;
    assign w_dc    = w_nc - 11'd1;
    assign w_dr    = w_nr - 11'd1;
    assign w_alpha = (r_alpha == 16'd0) ? 16'd1 : r_alpha;
    assign w_eta0  = (r_eta0 == 16'd0) ? 16'd1 : r_eta0;
    assign w_rest  = ONE_Q16 - {1'b0, w_eta0};

    logic r_out_valid;
    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_req.ready = w_adv;

    // input stage
    logic       r0_valid;
    logic       r0_err;
    logic       r0_bot;
    logic       r0_top;
    logic [9:0] r0_col;
    logic [9:0] r0_row;
    logic       n0_err;

    assign n0_err = (w_nc < 11'd2) || (w_nr < 11'd2)
                 || ({1'b0, i_req.data.column_index} >= w_nc)
                 || ({1'b0, i_req.data.row_index} >= w_nr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_err <= n0_err;
            r0_bot <= i_req.data.row_index == 10'd0;
            r0_top <= {1'b0, i_req.data.row_index} == w_dr;
            r0_col <= i_req.data.column_index;
            r0_row <= i_req.data.row_index;
        end
    end

    // column and row ratios
    logic [16:0] w_qx;
    logic [16:0] w_qe;
    logic [1:0]  w_sx;
    logic [1:0]  w_se;

    ecgp_div #(.NW(28), .DW(11), .QW(17), .SW(2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_num   (28'({r0_col, 17'd0}) + 28'(w_dc)),
        .i_den   ({w_dc[9:0], 1'b0}),
        .i_side  ({r0_valid, r0_err}),
        .o_quo   (w_qx),
        .o_ovf   (),
        .o_side  (w_sx)
    );

    ecgp_div #(.NW(28), .DW(11), .QW(17), .SW(2)) u_div_eta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_num   (28'({r0_row, 17'd0}) + 28'(w_dr)),
        .i_den   ({w_dr[9:0], 1'b0}),
        .i_side  ({r0_bot, r0_top}),
        .o_quo   (w_qe),
        .o_ovf   (),
        .o_side  (w_se)
    );

    // side select and local height
    t_tag        n1_tag;
    t_tag        r1_tag;
    logic [16:0] r1_num;
    logic [16:0] r1_den;

    always_comb begin
        n1_tag.valid = w_sx[1];
        n1_tag.err   = w_sx[0];
        n1_tag.bot   = w_se[1];
        n1_tag.top   = w_se[0];
        n1_tag.up    = w_qe > {1'b0, w_eta0};
        n1_tag.x     = w_qx;
        n1_tag.h     = 21'(r_base) + 21'(w_qx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
        end else if (w_adv) begin
            r1_tag <= n1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_num <= n1_tag.up ? (w_qe - {1'b0, w_eta0}) : w_qe;
            r1_den <= n1_tag.up ? w_rest : {1'b0, w_eta0};
        end
    end

    // stretch coordinate t or s
    logic [16:0] w_qt;
    t_tag        w_tt;

    ecgp_div #(.NW(33), .DW(17), .QW(17), .SW($bits(t_tag))) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_num   ({r1_num, 16'd0}),
        .i_den   (r1_den),
        .i_side  (r1_tag),
        .o_quo   (w_qt),
        .o_ovf   (),
        .o_side  (w_tt)
    );

    // exp argument alpha * t in Q.28
    t_tag        r2_tag;
    logic [32:0] r2_prod;
    logic [16:0] w_tp;

    assign w_tp = w_tt.up ? (ONE_Q16 - w_qt) : w_qt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_tag <= '0;
        end else if (w_adv) begin
            r2_tag <= w_tt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_prod <= 33'(w_alpha) * 33'(w_tp);
        end
    end

    logic [30:0] w_e;
    logic [30:0] w_ea;
    t_tag        w_te;
    logic        w_upa;

    ecgp_exp #(.SW($bits(t_tag))) u_exp_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_u     (22'((34'(r2_prod) + 34'd2048) >> 12)),
        .i_side  (r2_tag),
        .o_e     (w_e),
        .o_side  (w_te)
    );

    ecgp_exp #(.SW(1)) u_exp_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_u     (22'({w_alpha, 4'd0})),
        .i_side  (r2_tag.up),
        .o_e     (w_ea),
        .o_side  (w_upa)
    );

    // numerator and denominator of the stretch factor
    t_tag        r3_tag;
    logic [30:0] r3_num;
    logic [30:0] r3_den;
    logic [30:0] w_d;

    assign w_d = ONE_Q30 - w_ea;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_tag <= '0;
        end else if (w_adv) begin
            r3_tag <= w_te;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_upa) begin
                r3_num <= (w_e > w_ea) ? (w_e - w_ea) : 31'd0;
            end else begin
                r3_num <= (ONE_Q30 > w_e) ? (ONE_Q30 - w_e) : 31'd0;
            end
            r3_den <= (w_d == 31'd0) ? 31'd1 : w_d;
        end
    end

    logic [16:0] w_qf;
    logic        w_of;
    t_tag        w_tf;

    ecgp_div #(.NW(47), .DW(31), .QW(17), .SW($bits(t_tag))) u_div_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_num   ({r3_num, 16'd0} + 47'(r3_den[30:1])),
        .i_den   (r3_den),
        .i_side  (r3_tag),
        .o_quo   (w_qf),
        .o_ovf   (w_of),
        .o_side  (w_tf)
    );

    // height products
    t_tag        r4_tag;
    logic [16:0] r4_f;
    logic [36:0] r4_p1;
    logic [37:0] r4_p2;
    logic [16:0] w_f;

    assign w_f = (w_of || (w_qf > ONE_Q16)) ? ONE_Q16 : w_qf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_tag <= '0;
        end else if (w_adv) begin
            r4_tag <= w_tf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_f  <= w_f;
            r4_p1 <= 37'(w_tf.h) * 37'(w_eta0);
            r4_p2 <= 38'(w_tf.h) * 38'(w_rest);
        end
    end

    t_tag        r5_tag;
    logic [54:0] r5_prod;
    logic [52:0] r5_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_tag <= '0;
        end else if (w_adv) begin
            r5_tag <= r4_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_prod <= 55'(r4_tag.up ? r4_p2 : {1'b0, r4_p1}) * 55'(r4_f);
            r5_add  <= r4_tag.up ? {r4_p1, 16'd0} : 53'd0;
        end
    end

    // round, clamp and output register
    logic [56:0] w_sum;
    logic [24:0] w_yq;
    logic [20:0] w_ycap;
    logic [20:0] n_y;
    logic [16:0] r_out_x;
    logic [20:0] r_out_y;
    logic        r_out_err;

    assign w_sum  = 57'(r5_prod) + 57'(r5_add) + (57'd1 << 31);
    assign w_yq   = w_sum[56:32];
    assign w_ycap = (w_yq > 25'(r5_tag.h)) ? r5_tag.h : w_yq[20:0];

    always_comb begin
        priority if (r5_tag.err || r5_tag.bot) begin
            n_y = 21'd0;
        end else if (r5_tag.top) begin
            n_y = r5_tag.h;
        end else begin
            n_y = w_ycap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r5_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x   <= r5_tag.err ? 17'd0 : r5_tag.x;
            r_out_y   <= n_y;
            r_out_err <= r5_tag.err;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.data.x_coord     = r_out_x;
    assign o_res.data.y_coord     = r_out_y;
    assign o_res.data.index_error = r_out_err;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid survived reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r5_prod) && $stable(r3_num) && $stable(r1_num))
        else $error("pipeline moved during a stall");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_err |-> r_out_x <= ONE_Q16)
        else $error("x beyond one");

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_err |-> r_out_y <= 21'd1114111)
        else $error("y beyond maximum height");

endmodule

`default_nettype wire

// ===== verif/exponential_cluster_grid_point_unit_test.sv =====
// Self-checking testbench for the exponential cluster grid point unit: drives node requests,
// predicts x, y and the index error flag in fixed point, and compares every result beat.
// Depends on ecgp_pkg, ecgp_chan and the unit's RTL.
`timescale 1ns / 100ps

module exponential_cluster_grid_point_unit_test;
    import ecgp_pkg::*;

    localparam int IDX_COLS  = 0;
    localparam int IDX_ROWS  = 1;
    localparam int IDX_BASE  = 2;
    localparam int IDX_ALPHA = 3;
    localparam int IDX_ETA0  = 4;
    localparam int IDX_NONE  = 6;
    localparam int DRAIN_CYCLES = 80;
    localparam int STALL_LIMIT  = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    ecgp_chan #(.T(t_req)) req_ch ();
    ecgp_chan #(.T(t_res)) res_ch ();

    exponential_cluster_grid_point_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    // predictor copy of the registers
    logic [10:0] cols_q;
    logic [10:0] rows_q;
    logic [19:0] base_q;
    logic [15:0] alpha_q;
    logic [15:0] eta0_q;

    t_req pending_reqs[$];
    t_res expected_nodes[$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_send;
    int   quiet_cycles;

    longint unsigned exp_frac_tab [65];
    longint unsigned exp_whole_tab [17];

    function automatic longint unsigned series_exp(int k);
        longint unsigned term;
        longint unsigned sum;
        term = 64'd1 << 32;
        sum  = term;
        for (int n = 1; n <= 24; n++) begin
            term = term * longint'(k) / longint'(64 * n);
            if (term == 0) break;
            sum += term;
        end
        return ((64'd1 << 62) + sum / 2) / sum;
    endfunction

    function automatic longint unsigned exp_neg_q30(longint unsigned u);
        longint unsigned j;
        longint unsigned f;
        longint unsigned a;
        longint unsigned b;
        longint unsigned v;
        j = u >> 16;
        if (j > 16) return 0;
        f = u & 64'hFFFF;
        a = exp_frac_tab[f >> 10];
        b = exp_frac_tab[(f >> 10) + 1];
        if (b > a) b = a;
        v = a - (((a - b) * (f & 1023) + 512) >> 10);
        return (v * exp_whole_tab[j] + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned round_ratio(longint unsigned i, longint unsigned d);
        return ((i << 17) + d) / (d << 1);
    endfunction

    function automatic longint unsigned stretch_frac(longint unsigned n, longint unsigned d);
        longint unsigned f;
        f = ((n << 16) + d / 2) / d;
        return f > 65536 ? 65536 : f;
    endfunction

    function automatic t_res grid_node(t_req rq);
        t_res r;
        longint unsigned nc, nr, alpha, eta0, col, row;
        longint unsigned x, h, y, eta, ea, d, num, f, t, u, e, rest, s;
        nc    = cols_q > MAX_POINTS ? MAX_POINTS : cols_q;
        nr    = rows_q > MAX_POINTS ? MAX_POINTS : rows_q;
        alpha = alpha_q ? alpha_q : 1;
        eta0  = eta0_q ? eta0_q : 1;
        col   = rq.column_index;
        row   = rq.row_index;
        r     = '0;
        if (nc < 2 || nr < 2 || col >= nc || row >= nr) begin
            r.index_error = 1'b1;
            return r;
        end
        x = round_ratio(col, nc - 1);
        h = base_q + x;
        if (row == 0) begin
            y = 0;
        end else if (row == nr - 1) begin
            y = h;
        end else begin
            eta = round_ratio(row, nr - 1);
            ea  = exp_neg_q30(alpha << 4);
            d   = (64'd1 << 30) > ea ? (64'd1 << 30) - ea : 0;
            if (d == 0) d = 1;
            if (eta <= eta0) begin
                t   = (eta << 16) / eta0;
                u   = (alpha * t + 2048) >> 12;
                e   = exp_neg_q30(u);
                num = (64'd1 << 30) > e ? (64'd1 << 30) - e : 0;
                f   = stretch_frac(num, d);
                y   = (h * eta0 * f + (64'd1 << 31)) >> 32;
            end else begin
                rest = 65536 - eta0;
                s    = ((eta - eta0) << 16) / rest;
                if (s > 65536) s = 65536;
                u   = (alpha * (65536 - s) + 2048) >> 12;
                e   = exp_neg_q30(u);
                num = e > ea ? e - ea : 0;
                f   = stretch_frac(num, d);
                y   = (h * eta0 * 65536 + h * rest * f + (64'd1 << 31)) >> 32;
            end
            if (y > h) y = h;
        end
        r.x_coord = x[16:0];
        r.y_coord = y[20:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic write_reg(int idx, logic [19:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[2:0];
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            IDX_COLS:  cols_q  = val[10:0];
            IDX_ROWS:  rows_q  = val[10:0];
            IDX_BASE:  base_q  = val;
            IDX_ALPHA: alpha_q = val[15:0];
            IDX_ETA0:  eta0_q  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_nodes.size() != 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_node(int c, int r);
        t_req rq;
        rq.column_index = c[9:0];
        rq.row_index    = r[9:0];
        pending_reqs.push_back(rq);
    endtask

    task automatic queue_random(int n);
        int nc, nr;
        nc = cols_q > MAX_POINTS ? MAX_POINTS : cols_q;
        nr = rows_q > MAX_POINTS ? MAX_POINTS : rows_q;
        if (nc < 1) nc = 1;
        if (nr < 1) nr = 1;
        repeat (n) begin
            case ($urandom_range(9))
                0: queue_node($urandom_range(1023), $urandom_range(1023));
                1: queue_node($urandom_range(nc - 1), $urandom_range(1) ? 0 : nr - 1);
                default: queue_node($urandom_range(nc - 1), $urandom_range(nr - 1));
            endcase
        end
    endtask

    task automatic set_grid(int c, int r, int b, int a, int e0);
        wait_drained();
        write_reg(IDX_COLS, c);
        write_reg(IDX_ROWS, r);
        write_reg(IDX_BASE, b);
        write_reg(IDX_ALPHA, a);
        write_reg(IDX_ETA0, e0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && !hold_send &&
                    $urandom_range(99) >= send_idle_pct) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_reqs.pop_front();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            res_ch.ready <= $urandom_range(99) >= recv_idle_pct;
            if (req_ch.valid && req_ch.ready)
                expected_nodes.push_back(grid_node(req_ch.data));
            if (res_ch.valid && res_ch.ready) begin
                if (expected_nodes.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = expected_nodes.pop_front();
                    if (res_ch.data.x_coord !== want.x_coord)
                        report_mismatch("x_coord", res_ch.data.x_coord, want.x_coord);
                    if (res_ch.data.y_coord !== want.y_coord)
                        report_mismatch("y_coord", res_ch.data.y_coord, want.y_coord);
                    if (res_ch.data.index_error !== want.index_error)
                        report_mismatch("index_error", res_ch.data.index_error,
                                        want.index_error);
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        for (int k = 0; k < 65; k++) exp_frac_tab[k] = series_exp(k);
        exp_whole_tab[0] = 64'd1 << 30;
        for (int j = 1; j < 17; j++)
            exp_whole_tab[j] = (exp_whole_tab[j - 1] * exp_frac_tab[64] + (64'd1 << 29)) >> 30;
        errors        = 0;
        hold_send     = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 78;
        cols_q  = 50;
        rows_q  = 50;
        base_q  = 32768;
        alpha_q = 20480;
        eta0_q  = 45875;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings first, then edge-case grids
        queue_node(0, 0);
        queue_node(49, 49);
        queue_node(25, 34);
        queue_node(25, 35);
        queue_node(10, 20);
        queue_node(49, 48);
        queue_node(50, 0);
        queue_node(0, 50);
        queue_node(1023, 1023);
        queue_node(682, 341);
        wait_drained();
        write_reg(IDX_NONE, 20'hFFFFF);
        set_grid(2047, 1025, 20'hFFFFF, 65535, 65535);
        queue_node(1023, 1022);
        queue_node(1023, 1023);
        queue_node(0, 1);
        queue_node(512, 1021);
        set_grid(2, 3, 0, 0, 0);
        queue_node(1, 1);
        queue_node(0, 1);
        queue_node(2, 0);
        queue_node(0, 2);
        set_grid(1, 0, 100, 1, 1);
        queue_node(0, 0);
        queue_node(0, 1);
        set_grid(1024, 1024, 65536, 4096, 32768);
        queue_node(1, 511);

        // random phases
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: set_grid(50, 50, 32768, 20480, 45875);
                1: set_grid(1024, 1024, $urandom_range(20'hFFFFF), $urandom_range(65535),
                            $urandom_range(65535));
                2: set_grid(2, 2, 0, 1, 1);
                3: set_grid($urandom_range(2047), $urandom_range(2047),
                            $urandom_range(20'hFFFFF), $urandom_range(65535),
                            $urandom_range(65535));
                default: set_grid($urandom_range(2, 300), $urandom_range(2, 300),
                                  $urandom_range(20'hFFFFF), $urandom_range(1, 65535),
                                  $urandom_range(1, 65535));
            endcase
            if (p == 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 37;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_random(85);
            while (pending_reqs.size() != 0) @(posedge i_clk);
            // hold off until every result is back
            hold_send = 1'b1;
            while (expected_nodes.size() != 0 || req_ch.valid) @(posedge i_clk);
            hold_send = 1'b0;
            queue_random(85);
        end

        wait_drained();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
